// File: hw/rtl/smax_pkg.sv
`timescale 1ns / 1ps

package smax_pkg;

  localparam int NUM_CLASSES_DEF = 8;
  localparam int LOGIT_W         = 16;
  localparam int EXP_W           = 16;
  localparam int CLS_W           = 3;

  typedef struct packed {
    logic signed [LOGIT_W-1:0] logit;
    logic                      last;
  } smax_in_t;

  typedef struct packed {
    logic [CLS_W-1:0] class_index;
    logic [EXP_W-1:0] probability;
    logic [CLS_W-1:0] predicted_class;
    logic [EXP_W-1:0] confidence;
    logic             last_result;
  } smax_out_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_RD_LOGIT,
    ST_EXP_SETUP,
    ST_TAY_MUL,
    ST_TAY_DIVLD,
    ST_TAY_DIV,
    ST_TAY_ACC,
    ST_SQ_LD,
    ST_SQ_MUL,
    ST_SQ_NEXT,
    ST_EXP_DONE,
    ST_CONF_LD,
    ST_CONF_DIV,
    ST_CONF_DONE,
    ST_RD_EXP,
    ST_PROB_LD,
    ST_PROB_DIV,
    ST_PROB_DONE
  } smax_state_t;

endpackage

// File: hw/rtl/smax_ram.sv
`timescale 1ns / 1ps

module smax_ram #(
  parameter int DATA_W = smax_pkg::LOGIT_W,
  parameter int DEPTH  = smax_pkg::NUM_CLASSES_DEF
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                           rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/softmax_argmax_core.sv
`timescale 1ns / 1ps

// Softmax with argmax over up to NUM_CLASSES signed Q8.8 scores. While busy is low, one score
// word is taken per cycle; words beyond NUM_CLASSES are dropped, and a word with last set
// starts the evaluation and raises busy. Each class then evaluates a series for its exponent,
// term by term, the last term zero or the sixtieth (one term for the top class, about 21 for
// the widest differences); every term needs a 64-bit product built from four 32-bit partial
// products in one shared multiplier and a 64-step bit-serial divide by the term index. A
// class below the exponent cutoff skips the series and gets a zero exponent. The confidence
// is computed next, then each result word in turn is set by a 33-step divide by the exponent
// sum. Results are one-cycle strobes on out_valid that the receiver cannot stall; busy falls
// in the cycle of the final result.

module softmax_argmax_core #(
  parameter int NUM_CLASSES = smax_pkg::NUM_CLASSES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  smax_pkg::smax_in_t  in_word,
  output logic                out_valid,
  output smax_pkg::smax_out_t out_word
);

  localparam int IDX_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CNT_W    = $clog2(NUM_CLASSES + 1);
  localparam int SUM_W    = smax_pkg::EXP_W + $clog2(NUM_CLASSES);
  localparam int TAY_ITER = 64;
  localparam int PRB_ITER = 33;
  localparam int PRB_PAD  = 64 - PRB_ITER;
  localparam int MAX_TERM = 60;

  smax_pkg::smax_state_t state_r, state_nxt;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [15:0]      max_r, max_nxt;
  logic [IDX_W-1:0]        max_idx_r, max_idx_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic                    out_valid_r, out_valid_nxt;
  smax_pkg::smax_out_t     out_word_r, out_word_nxt;

  logic [63:0]             mul_a_r, mul_a_nxt;
  logic [63:0]             mul_b_r, mul_b_nxt;
  logic [63:0]             pp_r, pp_nxt;
  logic [1:0]              sh_r, sh_nxt;
  logic [127:0]            prod_r, prod_nxt;
  logic [2:0]              step_r, step_nxt;
  logic [63:0]             dvd_r, dvd_nxt;
  logic [SUM_W-1:0]        rem_r, rem_nxt;
  logic [SUM_W-1:0]        dsr_r, dsr_nxt;
  logic [6:0]              dcnt_r, dcnt_nxt;
  logic [63:0]             acc_r, acc_nxt;
  logic [5:0]              n_r, n_nxt;
  logic [1:0]              sq_r, sq_nxt;
  logic [15:0]             conf_e_r, conf_e_nxt;
  logic [15:0]             conf_r, conf_nxt;

  logic                    accept;
  logic                    store_ok;
  logic                    last_idx;
  logic                    logit_we;
  logic [15:0]             logit_rdata;
  logic                    exp_we;
  logic [15:0]             exp_rdata;
  logic signed [16:0]      d_c;
  logic [16:0]             d_neg;
  logic                    too_low;
  logic [12:0]             k_c;
  logic [31:0]             op_x, op_y;
  logic [63:0]             pp_c;
  logic [127:0]            pp_shift;
  logic [127:0]            prod_sum;
  logic [SUM_W:0]          rem_sh, rem_dif;
  logic                    qbit;
  logic                    div_end;
  logic [64:0]             e_rnd;
  logic [15:0]             e_q16;
  logic [15:0]             q_sat;
  logic [15:0]             e_sel;
  logic [32:0]             numer;
  logic [6:0]              idx_ext, max_ext;

  assign busy      = (state_r != smax_pkg::ST_LOAD);
  assign accept    = start && !busy;
  assign store_ok  = (count_r < CNT_W'(NUM_CLASSES));
  assign last_idx  = (CNT_W'(idx_r) == (count_r - CNT_W'(1)));
  assign logit_we  = accept && store_ok;
  assign exp_we    = (state_r == smax_pkg::ST_EXP_DONE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  smax_ram #(
    .DATA_W(smax_pkg::LOGIT_W),
    .DEPTH (NUM_CLASSES)
  ) u_logit_ram (
    .clk  (clk),
    .we   (logit_we),
    .waddr(count_r[IDX_W-1:0]),
    .wdata(in_word.logit),
    .raddr(idx_r),
    .rdata(logit_rdata)
  );

  smax_ram #(
    .DATA_W(smax_pkg::EXP_W),
    .DEPTH (NUM_CLASSES)
  ) u_exp_ram (
    .clk  (clk),
    .we   (exp_we),
    .waddr(idx_r),
    .wdata(e_q16),
    .raddr(idx_r),
    .rdata(exp_rdata)
  );

  always_comb begin
    d_c     = $signed({logit_rdata[15], logit_rdata}) - $signed({max_r[15], max_r});
    d_neg   = 17'(-d_c);
    too_low = (d_c < -17'sd4096);
    k_c     = d_c[16] ? d_neg[12:0] : 13'd0;

    case (step_r[1:0])
      2'd0: begin
        op_x = mul_a_r[31:0];
        op_y = mul_b_r[31:0];
      end
      2'd1: begin
        op_x = mul_a_r[31:0];
        op_y = mul_b_r[63:32];
      end
      2'd2: begin
        op_x = mul_a_r[63:32];
        op_y = mul_b_r[31:0];
      end
      default: begin
        op_x = mul_a_r[63:32];
        op_y = mul_b_r[63:32];
      end
    endcase
    pp_c = op_x * op_y;

    case (sh_r)
      2'd0:    pp_shift = {64'd0, pp_r};
      2'd1:    pp_shift = {32'd0, pp_r, 32'd0};
      2'd2:    pp_shift = {pp_r, 64'd0};
      default: pp_shift = '0;
    endcase
    prod_sum = prod_r + pp_shift;

    rem_sh  = {rem_r, dvd_r[63]};
    rem_dif = rem_sh - {1'b0, dsr_r};
    qbit    = !rem_dif[SUM_W];
    div_end = (dcnt_r == 7'd1);

    e_rnd = {1'b0, acc_r} + (65'd1 << 45);
    e_q16 = (|e_rnd[64:62]) ? 16'hFFFF : e_rnd[61:46];
    q_sat = (|dvd_r[63:16]) ? 16'hFFFF : dvd_r[15:0];

    e_sel = (state_r == smax_pkg::ST_CONF_LD) ? conf_e_r : exp_rdata;
    numer = {1'b0, e_sel, 16'd0} + 33'(sum_r >> 1);

    idx_ext = 7'(idx_r);
    max_ext = 7'(max_idx_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smax_pkg::ST_LOAD: begin
        if (accept && in_word.last) begin
          state_nxt = smax_pkg::ST_RD_LOGIT;
        end
      end
      smax_pkg::ST_RD_LOGIT:  state_nxt = smax_pkg::ST_EXP_SETUP;
      smax_pkg::ST_EXP_SETUP: state_nxt = too_low ? smax_pkg::ST_EXP_DONE : smax_pkg::ST_TAY_MUL;
      smax_pkg::ST_TAY_MUL: begin
        if (step_r == 3'd4) begin
          state_nxt = smax_pkg::ST_TAY_DIVLD;
        end
      end
      smax_pkg::ST_TAY_DIVLD: state_nxt = smax_pkg::ST_TAY_DIV;
      smax_pkg::ST_TAY_DIV: begin
        if (div_end) begin
          state_nxt = smax_pkg::ST_TAY_ACC;
        end
      end
      smax_pkg::ST_TAY_ACC: begin
        if ((dvd_r == 64'd0) || (n_r == 6'(MAX_TERM))) begin
          state_nxt = smax_pkg::ST_SQ_LD;
        end else begin
          state_nxt = smax_pkg::ST_TAY_MUL;
        end
      end
      smax_pkg::ST_SQ_LD: state_nxt = smax_pkg::ST_SQ_MUL;
      smax_pkg::ST_SQ_MUL: begin
        if (step_r == 3'd4) begin
          state_nxt = smax_pkg::ST_SQ_NEXT;
        end
      end
      smax_pkg::ST_SQ_NEXT: begin
        state_nxt = (sq_r == 2'd3) ? smax_pkg::ST_EXP_DONE : smax_pkg::ST_SQ_LD;
      end
      smax_pkg::ST_EXP_DONE: begin
        state_nxt = last_idx ? smax_pkg::ST_CONF_LD : smax_pkg::ST_RD_LOGIT;
      end
      smax_pkg::ST_CONF_LD: state_nxt = smax_pkg::ST_CONF_DIV;
      smax_pkg::ST_CONF_DIV: begin
        if (div_end) begin
          state_nxt = smax_pkg::ST_CONF_DONE;
        end
      end
      smax_pkg::ST_CONF_DONE: state_nxt = smax_pkg::ST_RD_EXP;
      smax_pkg::ST_RD_EXP:    state_nxt = smax_pkg::ST_PROB_LD;
      smax_pkg::ST_PROB_LD:   state_nxt = smax_pkg::ST_PROB_DIV;
      smax_pkg::ST_PROB_DIV: begin
        if (div_end) begin
          state_nxt = smax_pkg::ST_PROB_DONE;
        end
      end
      smax_pkg::ST_PROB_DONE: begin
        state_nxt = last_idx ? smax_pkg::ST_LOAD : smax_pkg::ST_RD_EXP;
      end
      default: state_nxt = smax_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    max_nxt       = max_r;
    max_idx_nxt   = max_idx_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    pp_nxt        = pp_r;
    sh_nxt        = sh_r;
    prod_nxt      = prod_r;
    step_nxt      = step_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    dcnt_nxt      = dcnt_r;
    acc_nxt       = acc_r;
    n_nxt         = n_r;
    sq_nxt        = sq_r;
    conf_e_nxt    = conf_e_r;
    conf_nxt      = conf_r;

    case (state_r)
      smax_pkg::ST_LOAD: begin
        if (accept) begin
          if (store_ok) begin
            if ((count_r == '0) || (in_word.logit > max_r)) begin
              max_nxt     = in_word.logit;
              max_idx_nxt = count_r[IDX_W-1:0];
            end
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_word.last) begin
            idx_nxt = '0;
            sum_nxt = '0;
          end
        end
      end
      smax_pkg::ST_EXP_SETUP: begin
        if (too_low) begin
          acc_nxt = 64'd0;
        end else begin
          acc_nxt   = 64'd1 << 62;
          mul_a_nxt = 64'd1 << 62;
          mul_b_nxt = {1'b0, k_c, 50'd0};
          n_nxt     = 6'd1;
          step_nxt  = 3'd0;
          prod_nxt  = '0;
        end
      end
      smax_pkg::ST_TAY_MUL, smax_pkg::ST_SQ_MUL: begin
        if (step_r != 3'd4) begin
          pp_nxt = pp_c;
          sh_nxt = (step_r == 3'd0) ? 2'd0 : ((step_r == 3'd3) ? 2'd2 : 2'd1);
        end
        if (step_r != 3'd0) begin
          prod_nxt = prod_sum;
        end
        step_nxt = step_r + 3'd1;
      end
      smax_pkg::ST_TAY_DIVLD: begin
        dvd_nxt  = prod_r[125:62];
        rem_nxt  = '0;
        dsr_nxt  = SUM_W'(n_r);
        dcnt_nxt = 7'(TAY_ITER);
      end
      smax_pkg::ST_TAY_DIV, smax_pkg::ST_CONF_DIV, smax_pkg::ST_PROB_DIV: begin
        rem_nxt  = qbit ? rem_dif[SUM_W-1:0] : rem_sh[SUM_W-1:0];
        dvd_nxt  = {dvd_r[62:0], qbit};
        dcnt_nxt = dcnt_r - 7'd1;
      end
      smax_pkg::ST_TAY_ACC: begin
        sq_nxt = 2'd0;
        if (dvd_r != 64'd0) begin
          acc_nxt = n_r[0] ? (acc_r - dvd_r) : (acc_r + dvd_r);
          if (n_r != 6'(MAX_TERM)) begin
            n_nxt     = n_r + 6'd1;
            mul_a_nxt = dvd_r;
            step_nxt  = 3'd0;
            prod_nxt  = '0;
          end
        end
      end
      smax_pkg::ST_SQ_LD: begin
        mul_a_nxt = acc_r;
        mul_b_nxt = acc_r;
        step_nxt  = 3'd0;
        prod_nxt  = '0;
      end
      smax_pkg::ST_SQ_NEXT: begin
        acc_nxt = prod_r[125:62];
        sq_nxt  = sq_r + 2'd1;
      end
      smax_pkg::ST_EXP_DONE: begin
        sum_nxt = sum_r + SUM_W'(e_q16);
        if (idx_r == max_idx_r) begin
          conf_e_nxt = e_q16;
        end
        if (!last_idx) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      smax_pkg::ST_CONF_LD, smax_pkg::ST_PROB_LD: begin
        dvd_nxt  = {numer, {PRB_PAD{1'b0}}};
        rem_nxt  = '0;
        dsr_nxt  = sum_r;
        dcnt_nxt = 7'(PRB_ITER);
      end
      smax_pkg::ST_CONF_DONE: begin
        conf_nxt = q_sat;
        idx_nxt  = '0;
      end
      smax_pkg::ST_PROB_DONE: begin
        out_valid_nxt                = 1'b1;
        out_word_nxt.class_index     = idx_ext[smax_pkg::CLS_W-1:0];
        out_word_nxt.probability     = q_sat;
        out_word_nxt.predicted_class = max_ext[smax_pkg::CLS_W-1:0];
        out_word_nxt.confidence      = conf_r;
        out_word_nxt.last_result     = last_idx;
        if (last_idx) begin
          count_nxt   = '0;
          max_nxt     = -16'sd32768;
          max_idx_nxt = '0;
          sum_nxt     = '0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smax_pkg::ST_LOAD;
      count_r     <= '0;
      max_r       <= -16'sd32768;
      max_idx_r   <= '0;
      idx_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      max_r       <= max_nxt;
      max_idx_r   <= max_idx_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_b_r    <= mul_b_nxt;
    pp_r       <= pp_nxt;
    sh_r       <= sh_nxt;
    prod_r     <= prod_nxt;
    step_r     <= step_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    dsr_r      <= dsr_nxt;
    dcnt_r     <= dcnt_nxt;
    acc_r      <= acc_nxt;
    n_r        <= n_nxt;
    sq_r       <= sq_nxt;
    conf_e_r   <= conf_e_nxt;
    conf_r     <= conf_nxt;
  end

endmodule

// File: hw/rtl/smax_chk.sv
`timescale 1ns / 1ps

module smax_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input smax_pkg::smax_in_t  in_word,
  input logic                out_valid,
  input smax_pkg::smax_out_t out_word
);

  a_last_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_word.last |=> busy)
    else $error("busy did not rise after the final score word");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes in back-to-back cycles");

  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.last_result |-> busy)
    else $error("busy low while results are still pending");

  a_final_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last_result |-> !busy)
    else $error("busy still high with the final result");

  a_conf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.probability <= out_word.confidence)
    else $error("a probability exceeds the confidence of the predicted class");

endmodule

bind softmax_argmax_core smax_chk u_smax_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_word  (in_word),
  .out_valid(out_valid),
  .out_word (out_word)
);

// File: bench/softmax_argmax_checker.sv
`timescale 1ns / 1ps

module softmax_argmax_checker #(
  parameter int NUM_CLASSES = smax_pkg::NUM_CLASSES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  smax_pkg::smax_in_t  in_word,
  input  logic                out_valid,
  input  smax_pkg::smax_out_t out_word,
  output int                  fail_count,
  output int                  probs_outstanding
);
  import smax_pkg::*;

  localparam logic [63:0] Q62_ONE = 64'd1 << 62;

  logic signed [LOGIT_W-1:0] score_store [NUM_CLASSES];
  logic signed [LOGIT_W-1:0] top_score;
  int unsigned top_index;
  int unsigned scores_loaded;
  int errors;
  smax_out_t prob_words_due [$];

  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  function automatic logic [EXP_W-1:0] exp_q16(input int diff);
    logic [63:0] y, term, pos, neg, e, r;
    int n;
    bit done;
    if (diff < -4096) return '0;
    if (diff > 0) diff = 0;
    y = 64'(-diff) << 50;
    term = Q62_ONE;
    pos = Q62_ONE;
    neg = '0;
    done = 1'b0;
    for (n = 1; n <= 60 && !done; n++) begin
      term = q62_mul(term, y) / 64'(n);
      if (term == 0) begin
        done = 1'b1;
      end else if (n % 2 == 1) begin
        neg += term;
      end else begin
        pos += term;
      end
    end
    e = pos - neg;
    repeat (4) e = q62_mul(e, e);
    r = (e + (64'd1 << 45)) >> 46;
    return (r > 64'd65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic logic [EXP_W-1:0] prob_q16(input logic [EXP_W-1:0] e,
                                                input logic [31:0] total);
    logic [63:0] p;
    p = ((64'(e) << 16) + 64'(total >> 1)) / 64'(total);
    return (p > 64'd65535) ? 16'hFFFF : p[15:0];
  endfunction

  task automatic queue_vector_probs();
    logic [EXP_W-1:0] class_exp [NUM_CLASSES];
    logic [31:0] total;
    logic [EXP_W-1:0] conf;
    smax_out_t w;
    int i;
    total = '0;
    for (i = 0; i < scores_loaded; i++) begin
      class_exp[i] = exp_q16(int'(score_store[i]) - int'(top_score));
      total += 32'(class_exp[i]);
    end
    conf = prob_q16(class_exp[top_index], total);
    for (i = 0; i < scores_loaded; i++) begin
      w.class_index     = CLS_W'(i);
      w.probability     = prob_q16(class_exp[i], total);
      w.predicted_class = CLS_W'(top_index);
      w.confidence      = conf;
      w.last_result     = (i + 1 == scores_loaded);
      prob_words_due = {prob_words_due, w};
    end
  endtask

  task automatic load_score(input smax_in_t w);
    logic signed [LOGIT_W-1:0] score;
    score = w.logit;
    if (scores_loaded < NUM_CLASSES) begin
      score_store[scores_loaded] = score;
      if (scores_loaded == 0 || score > top_score) begin
        top_score = score;
        top_index = scores_loaded;
      end
      scores_loaded++;
    end
    if (w.last) begin
      queue_vector_probs();
      top_score = -16'sd32768;
      top_index = 0;
      scores_loaded = 0;
    end
  endtask

  always @(posedge clk) begin : monitor
    smax_out_t due;
    if (!rst_n) begin
      prob_words_due.delete();
      top_score = -16'sd32768;
      top_index = 0;
      scores_loaded = 0;
      errors = 0;
    end else begin
      if (out_valid) begin
        if (prob_words_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: class %0d prob %0d pred %0d conf %0d last %0b",
                   $time, out_word.class_index, out_word.probability,
                   out_word.predicted_class, out_word.confidence, out_word.last_result);
        end else begin
          due = prob_words_due.pop_front();
          if (out_word.class_index !== due.class_index ||
              out_word.probability !== due.probability ||
              out_word.predicted_class !== due.predicted_class ||
              out_word.confidence !== due.confidence ||
              out_word.last_result !== due.last_result) begin
            errors++;
            $display({"%0t: mismatch: expected class %0d prob %0d pred %0d conf %0d ",
                      "last %0b, got class %0d prob %0d pred %0d conf %0d last %0b"},
                     $time, due.class_index, due.probability, due.predicted_class,
                     due.confidence, due.last_result, out_word.class_index,
                     out_word.probability, out_word.predicted_class,
                     out_word.confidence, out_word.last_result);
          end
        end
      end
      if (start && !busy) load_score(in_word);
    end
    fail_count <= errors;
    probs_outstanding <= prob_words_due.size();
  end

endmodule

// File: bench/softmax_argmax_core_tb.sv
`timescale 1ns / 1ps

module softmax_argmax_core_tb;
  import smax_pkg::*;

  localparam int NUM_CLASSES    = NUM_CLASSES_DEF;
  localparam int RANDOM_SCORES  = 450;
  localparam int END_WAIT_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  smax_in_t in_word = '0;
  logic out_valid;
  smax_out_t out_word;
  int fail_count;
  int probs_outstanding;
  int burst_left = 4;
  int scores_sent = 0;

  softmax_argmax_core #(.NUM_CLASSES(NUM_CLASSES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  softmax_argmax_checker #(.NUM_CLASSES(NUM_CLASSES)) prob_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_word           (in_word),
    .out_valid         (out_valid),
    .out_word          (out_word),
    .fail_count        (fail_count),
    .probs_outstanding (probs_outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_score(input logic signed [LOGIT_W-1:0] score, input logic mark);
    smax_in_t w;
    int gap;
    w.logit = score;
    w.last = mark;
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_all_probs();
    start <= 1'b0;
    @(posedge clk);
    while (probs_outstanding != 0) @(posedge clk);
  endtask

  task automatic send_random_vector();
    int len, spread, base, val, i;
    int prev;
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(NUM_CLASSES + 1, NUM_CLASSES + 4)
                                      : $urandom_range(1, NUM_CLASSES);
    case ($urandom_range(0, 4))
      0: spread = 16;
      1: spread = 256;
      2: spread = 2048;
      3: spread = 4200;
      default: spread = 65536;
    endcase
    base = int'($urandom_range(0, 65535)) - 32768;
    prev = base;
    for (i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 7) == 0) begin
        val = prev;
      end else if (spread == 65536) begin
        val = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        val = base + int'($urandom_range(0, 2 * spread)) - spread;
      end
      if (val > 32767) val = 32767;
      if (val < -32768) val = -32768;
      prev = val;
      send_score(16'(val), i == len - 1);
    end
    scores_sent += len;
  endtask

  initial begin
    int waited;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Lone scores at both ends saturate to full probability, then both in one vector.
    send_score(16'sh7FFF, 1'b1);
    send_score(-16'sh8000, 1'b1);
    send_score(-16'sh8000, 1'b0);
    send_score(16'sh7FFF, 1'b1);
    // Equal scores share the probability and the first one is predicted.
    send_score(16'sd0, 1'b0);
    send_score(16'sd0, 1'b0);
    send_score(16'sd0, 1'b1);
    // Differences right at and just past the exponent cutoff.
    send_score(16'sd100, 1'b0);
    send_score(-16'sd3996, 1'b0);
    send_score(-16'sd3997, 1'b1);
    // A full store with a tie for the top score, then dropped words carrying larger scores.
    send_score(-16'sh8000, 1'b0);
    send_score(16'sd5, 1'b0);
    send_score(16'sd1000, 1'b0);
    send_score(-16'sd1, 1'b0);
    send_score(16'sd1000, 1'b0);
    send_score(16'sd256, 1'b0);
    send_score(-16'sd256, 1'b0);
    send_score(16'sd0, 1'b0);
    send_score(16'sd2000, 1'b0);
    send_score(16'sd3000, 1'b1);
    wait_all_probs();

    while (scores_sent < RANDOM_SCORES) begin
      send_random_vector();
      if ($urandom_range(0, 9) == 0) wait_all_probs();
    end

    start <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (probs_outstanding != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && probs_outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog at several times the slowest correct run.
  initial begin
    #50000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
